// ----- rtl/core/hps_pitch_tuner_indicator_defines.svh -----
// Assertion macros shared by the pitch tuner RTL.
`ifndef HPS_PITCH_TUNER_INDICATOR_DEFINES_SVH
`define HPS_PITCH_TUNER_INDICATOR_DEFINES_SVH

`ifndef SYNTH
`define HPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt assertion failed");
`define HPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt assertion failed");
`else
`define HPT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/hpt_pkg.sv -----
// Shared constants, types and codes of the pitch tuner.
package hpt_pkg;

    localparam int BINS         = 4096;
    localparam int BINS_LOG2    = $clog2(BINS);
    localparam int STORE_DEPTH  = (3 * BINS) / 8;
    localparam int PRODUCT_BINS = BINS / 8;
    localparam int CNT_W        = $clog2(BINS + 1);
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int K_W          = $clog2(PRODUCT_BINS);

    localparam int MAG_W   = 16;
    localparam int PROD1_W = 2 * MAG_W;
    localparam int PROD_W  = 3 * MAG_W;
    localparam int FREQ_W  = 18;
    localparam int BIN_W   = 9;
    localparam int IND_W   = 2;

    localparam int SCALE_W = 21;
    localparam logic [SCALE_W-1:0] CENTIHZ_SCALE = SCALE_W'(1100000);
    localparam int FP_W = K_W + SCALE_W;
    localparam logic [FREQ_W-1:0] FREQ_MAX =
        FREQ_W'((64'(PRODUCT_BINS - 1) * 64'(1100000)) / 64'(BINS));

    localparam int TARGET_W = 18;
    localparam int TOL_W    = 14;
    localparam int OFF_W    = 17;
    localparam int HOLD_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [IND_W-1:0] {
        IND_OFF  = 2'd0,
        IND_HIGH = 2'd1,
        IND_LOW  = 2'd2,
        IND_TUNE = 2'd3
    } ind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET    = 2'd0,
        CFG_TOLERANCE = 2'd1,
        CFG_OFF_BAND  = 2'd2,
        CFG_HOLD      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [TOL_W-1:0]    tolerance;
        logic [OFF_W-1:0]    off_band;
        logic [HOLD_W-1:0]   hold;
    } cfg_t;

    // One classified bin as it travels from the front to the back.
    typedef struct packed {
        logic [MAG_W-1:0]    mag;
        logic                wr;
        logic [STORE_AW-1:0] waddr;
        logic                prod;
        logic [K_W-1:0]      k;
        logic                last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/core/hpt_front.sv -----
// Front end: accepts bins, tracks the bin index and classifies each bin.
module hpt_front
    import hpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [MAG_W-1:0] magnitude,
    input  logic          last,
    input  queue_status_t q_status,
    output logic          push,
    output op_t           op
);

    logic [CNT_W-1:0] bin_cnt_reg;
    logic [1:0]       phase_reg;
    logic [CNT_W-1:0] k_cnt_reg;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // The bin index is tracked modulo three alongside its third, so bin 3k
    // is recognized without a divider.
    always_comb
    begin
        op.mag   = magnitude;
        op.wr    = bin_cnt_reg < CNT_W'(STORE_DEPTH);
        op.waddr = STORE_AW'(bin_cnt_reg);
        op.prod  = (phase_reg == 2'd0) && (k_cnt_reg != '0)
                   && (k_cnt_reg < CNT_W'(PRODUCT_BINS));
        op.k     = K_W'(k_cnt_reg);
        op.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg <= '0;
            phase_reg   <= '0;
            k_cnt_reg   <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                bin_cnt_reg <= '0;
                phase_reg   <= '0;
                k_cnt_reg   <= '0;
            end
            else if (bin_cnt_reg < CNT_W'(BINS))
            begin
                bin_cnt_reg <= bin_cnt_reg + CNT_W'(1);
                if (phase_reg == 2'd2)
                begin
                    phase_reg <= '0;
                    k_cnt_reg <= k_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/hpt_queue.sv -----
// Short queue of classified bins between the front and the back.
module hpt_queue
    import hpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  op_t           push_op,
    input  logic          pop,
    output op_t           head,
    output queue_status_t status
);

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/core/hpt_back.sv -----
// Back end: bin store, harmonic product pipeline, peak tracking and result.
module hpt_back
    import hpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  queue_status_t q_status,
    input  op_t           head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [IND_W-1:0]  indication,
    output logic              pitch_found,
    output logic [BIN_W-1:0]  peak_bin,
    output logic [FREQ_W-1:0] freq_centihz
);

    logic [MAG_W-1:0] store_mem [STORE_DEPTH];

    // Control of the pipeline and the frame end.
    logic fin_busy_reg;
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic f1_valid_reg, f2_valid_reg;
    logic out_valid_reg;
    logic [PROD_W-1:0] best_reg;
    logic [K_W-1:0]    best_bin_reg;
    logic [HOLD_W-1:0] silent_reg;
    ind_t              held_reg;

    // Payload along the pipeline.
    logic [MAG_W-1:0]   rd_a_reg, rd_b_reg;
    logic [MAG_W-1:0]   s2_mag_reg, s3_mag_reg;
    logic [K_W-1:0]     s2_k_reg, s3_k_reg, s4_k_reg;
    logic               s2_prod_reg, s3_prod_reg, s4_prod_reg;
    logic               s2_last_reg, s3_last_reg, s4_last_reg;
    logic [PROD1_W-1:0] s3_p1_reg;
    logic [PROD_W-1:0]  s4_p_reg;
    logic [FREQ_W-1:0]  f_freq_reg;
    logic               f_found_reg;
    logic [K_W-1:0]     f_bin_reg;
    logic [IND_W-1:0]   ind_out_reg;
    logic               found_out_reg;
    logic [BIN_W-1:0]   bin_out_reg;
    logic [FREQ_W-1:0]  freq_out_reg;

    logic [FP_W-1:0]     fp;
    logic [FREQ_W-1:0]   freq_next;
    logic                better;
    logic [TARGET_W:0]   bound_off, bound_tol, freq_plus_tol;
    ind_t                class_ind;
    logic [HOLD_W:0]     silent_inc;
    logic [HOLD_W-1:0]   silent_next;
    ind_t                held_next;
    logic                take;

    // A frame end waits for the previous result to leave, and holds off
    // the next frame's bins until its own result is loaded.
    assign pop  = !q_status.empty && !fin_busy_reg && (!head.last || !out_valid_reg);
    assign take = out_valid_reg && !out_stall;

    assign better = s4_valid_reg && s4_prod_reg && (s4_p_reg > best_reg);

    assign fp        = FP_W'(best_bin_reg) * FP_W'(CENTIHZ_SCALE);
    assign freq_next = FREQ_W'(fp >> BINS_LOG2);

    always_comb
    begin
        bound_off     = (TARGET_W + 1)'(cfg.target) + (TARGET_W + 1)'(cfg.off_band);
        bound_tol     = (TARGET_W + 1)'(cfg.target) + (TARGET_W + 1)'(cfg.tolerance);
        freq_plus_tol = (TARGET_W + 1)'(f_freq_reg) + (TARGET_W + 1)'(cfg.tolerance);
        if ((TARGET_W + 1)'(f_freq_reg) > bound_off)
        begin
            class_ind = IND_OFF;
        end
        else if ((TARGET_W + 1)'(f_freq_reg) > bound_tol)
        begin
            class_ind = IND_HIGH;
        end
        else if (freq_plus_tol < (TARGET_W + 1)'(cfg.target))
        begin
            class_ind = IND_LOW;
        end
        else
        begin
            class_ind = IND_TUNE;
        end

        silent_inc  = (HOLD_W + 1)'(silent_reg) + (HOLD_W + 1)'(1);
        silent_next = silent_reg;
        held_next   = held_reg;
        if (f_found_reg)
        begin
            silent_next = '0;
            held_next   = class_ind;
        end
        else if (silent_inc > (HOLD_W + 1)'(cfg.hold))
        begin
            silent_next = cfg.hold;
            held_next   = IND_OFF;
        end
        else
        begin
            silent_next = HOLD_W'(silent_inc);
        end
    end

    // Bin store: one write and two reads per transaction, read data registered.
    always_ff @(posedge clk)
    begin
        if (pop && head.wr)
        begin
            store_mem[head.waddr] <= head.mag;
        end
        if (pop)
        begin
            rd_a_reg <= store_mem[STORE_AW'(head.k)];
            rd_b_reg <= store_mem[STORE_AW'({head.k, 1'b0})];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mag_reg  <= head.mag;
        s2_k_reg    <= head.k;
        s2_prod_reg <= head.prod;
        s2_last_reg <= head.last;

        s3_p1_reg   <= PROD1_W'(rd_a_reg) * PROD1_W'(rd_b_reg);
        s3_mag_reg  <= s2_mag_reg;
        s3_k_reg    <= s2_k_reg;
        s3_prod_reg <= s2_prod_reg;
        s3_last_reg <= s2_last_reg;

        s4_p_reg    <= PROD_W'(s3_p1_reg) * PROD_W'(s3_mag_reg);
        s4_k_reg    <= s3_k_reg;
        s4_prod_reg <= s3_prod_reg;
        s4_last_reg <= s3_last_reg;

        if (f1_valid_reg)
        begin
            f_freq_reg  <= freq_next;
            f_found_reg <= best_reg != '0;
            f_bin_reg   <= best_bin_reg;
        end

        if (f2_valid_reg)
        begin
            ind_out_reg   <= held_next;
            found_out_reg <= f_found_reg;
            bin_out_reg   <= BIN_W'(f_bin_reg);
            freq_out_reg  <= f_freq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_busy_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            best_reg      <= '0;
            best_bin_reg  <= '0;
            silent_reg    <= '0;
            held_reg      <= IND_OFF;
        end
        else
        begin
            s2_valid_reg <= pop;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            f1_valid_reg <= s4_valid_reg && s4_last_reg;
            f2_valid_reg <= f1_valid_reg;

            if (pop && head.last)
            begin
                fin_busy_reg <= 1'b1;
            end
            else if (f2_valid_reg)
            begin
                fin_busy_reg <= 1'b0;
            end

            // The frame's peak is captured in the cycle after the last bin's
            // compare, then cleared for the next frame.
            if (f1_valid_reg)
            begin
                best_reg     <= '0;
                best_bin_reg <= '0;
            end
            else if (better)
            begin
                best_reg     <= s4_p_reg;
                best_bin_reg <= s4_k_reg;
            end

            if (f2_valid_reg)
            begin
                silent_reg    <= silent_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign indication   = ind_out_reg;
    assign pitch_found  = found_out_reg;
    assign peak_bin     = bin_out_reg;
    assign freq_centihz = freq_out_reg;

endmodule

// ----- rtl/core/hps_pitch_tuner_indicator.sv -----
// Top level of the harmonic product spectrum pitch tuner.
// Spectrum bins enter one per cycle while the four-entry queue has room; the
// back end retires one queued bin per cycle, except while a frame end is in
// progress, through the bin store, a two-stage product pipeline and the peak
// compare. A frame's last bin passes from the queue through the product and
// frame-end stages to the result register, and the next frame's bins wait in
// the queue meanwhile. A last bin also waits in the queue until the previous
// result has been taken. Configuration writes are accepted on every cycle.
`include "hps_pitch_tuner_indicator_defines.svh"

module hps_pitch_tuner_indicator
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MAG_W-1:0]      magnitude,
    input  logic                  last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IND_W-1:0]      indication,
    output logic                  pitch_found,
    output logic [BIN_W-1:0]      peak_bin,
    output logic [FREQ_W-1:0]     freq_centihz,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t          cfg_reg;
    queue_status_t q_status;
    op_t           push_op;
    op_t           head;
    logic          push;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target    <= TARGET_W'(8241);
            cfg_reg.tolerance <= TOL_W'(140);
            cfg_reg.off_band  <= OFF_W'(2000);
            cfg_reg.hold      <= HOLD_W'(5);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TARGET:    cfg_reg.target    <= TARGET_W'(cfg_data);
                CFG_TOLERANCE: cfg_reg.tolerance <= TOL_W'(cfg_data);
                CFG_OFF_BAND:  cfg_reg.off_band  <= OFF_W'(cfg_data);
                CFG_HOLD:      cfg_reg.hold      <= HOLD_W'(cfg_data);
            endcase
        end
    end

    hpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .magnitude (magnitude),
        .last      (last),
        .q_status  (q_status),
        .push      (push),
        .op        (push_op)
    );

    hpt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    hpt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .indication   (indication),
        .pitch_found  (pitch_found),
        .peak_bin     (peak_bin),
        .freq_centihz (freq_centihz)
    );

    // A frame without a peak reports neither a bin nor a frequency.
    `HPT_ASSERT_IMPLIES(a_silent_zero, clk, rst_n, out_valid && !pitch_found, peak_bin == '0 && freq_centihz == '0)
    // A found peak lies at bin one or above and within the product range.
    `HPT_ASSERT_IMPLIES(a_found_range, clk, rst_n, out_valid && pitch_found, peak_bin != '0 && freq_centihz <= FREQ_MAX)
    // The next result cannot follow a taken one in the very next cycle.
    `HPT_ASSERT_NEXT(a_result_gap, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

// ----- verif/tb_hps_pitch_tuner_indicator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the harmonic product spectrum pitch tuner.
module tb;
    import hpt_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam longint unsigned HZ_SCALE = 1100000;

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_RAND, FILL_SPARSE, FILL_SPIKE, FILL_TWIN} fill_t;

    typedef struct packed {
        logic [IND_W-1:0]  indication;
        logic              pitch_found;
        logic [BIN_W-1:0]  peak_bin;
        logic [FREQ_W-1:0] freq_centihz;
    } reading_t;

    typedef struct {
        fill_t    fill;
        int       len;
        int       k;
        bit       typed;
        reading_t want;
    } frame_plan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MAG_W-1:0]      magnitude = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [IND_W-1:0]      indication;
    logic                  pitch_found;
    logic [BIN_W-1:0]      peak_bin;
    logic [FREQ_W-1:0]     freq_centihz;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the tuner: configuration and frame state.
    logic [TARGET_W-1:0] tgt_centihz = 18'd8241;
    logic [TOL_W-1:0]    tol_centihz = 14'd140;
    logic [OFF_W-1:0]    off_centihz = 17'd2000;
    logic [HOLD_W-1:0]   hold_limit  = 3'd5;
    logic [MAG_W-1:0]    spectrum_copy [STORE_DEPTH];
    int unsigned         bins_seen = 0;
    logic [63:0]         top_product = '0;
    int unsigned         top_bin = 0;
    int unsigned         quiet_frames = 0;
    logic [IND_W-1:0]    shown_ind = IND_OFF;

    reading_t         pending_readings [$];
    bit               use_typed = 1'b0;
    reading_t         typed_reading = '0;
    int               fail_count = 0;
    int               idle_cycles = 0;
    bit               gaps_on = 1'b1;
    int               stall_mode = 1;
    int unsigned      stall_run = 0;
    int unsigned      cyc_count = 0;
    int               burst_left = 0;
    logic [MAG_W-1:0] frame_bins [$];

    frame_plan_t directed_plan [16] = '{
        // Silent frames straight after reset keep the indication off.
        '{FILL_ZERO,    1,  0, 1'b1, '{IND_OFF,  1'b0, 9'd0,  18'd0}},
        '{FILL_MAX,     3,  0, 1'b1, '{IND_OFF,  1'b0, 9'd0,  18'd0}},
        // Four full-scale bins form exactly one product, the one for bin 1.
        '{FILL_MAX,     4,  0, 1'b1, '{IND_LOW,  1'b1, 9'd1,  18'd268}},
        '{FILL_SPIKE,  94, 31, 1'b1, '{IND_TUNE, 1'b1, 9'd31, 18'd8325}},
        // The tuned indication is held through five silent frames, then cleared.
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_TUNE, 1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_TUNE, 1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_TUNE, 1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_TUNE, 1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_TUNE, 1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_OFF,  1'b0, 9'd0,  18'd0}},
        '{FILL_ZERO,    2,  0, 1'b1, '{IND_OFF,  1'b0, 9'd0,  18'd0}},
        '{FILL_SPIKE,  91, 30, 1'b0, '0},
        '{FILL_SPIKE,  97, 32, 1'b0, '0},
        '{FILL_SPIKE, 118, 39, 1'b0, '0},
        // Equal products at bins 5 and 7: the earlier one wins.
        '{FILL_TWIN,   22,  5, 1'b1, '{IND_LOW,  1'b1, 9'd5,  18'd1342}},
        '{FILL_RAND,   40,  0, 1'b0, '0}
    };

    hps_pitch_tuner_indicator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .magnitude    (magnitude),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .indication   (indication),
        .pitch_found  (pitch_found),
        .peak_bin     (peak_bin),
        .freq_centihz (freq_centihz),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [IND_W-1:0] grade_pitch(input logic [63:0] freq);
        logic [63:0] t;
        t = 64'(tgt_centihz);
        if (freq > t + 64'(off_centihz))
            return IND_OFF;
        if (freq > t + 64'(tol_centihz))
            return IND_HIGH;
        // The low bound is written as a sum so that it never goes negative.
        if (freq + 64'(tol_centihz) < t)
            return IND_LOW;
        return IND_TUNE;
    endfunction

    function automatic void tuner_step(input logic [MAG_W-1:0] mag, input logic is_last);
        int unsigned idx;
        int unsigned k;
        logic [63:0] prod;
        logic [63:0] freq;
        bit          found;
        reading_t    r;
        idx = bins_seen;
        if (idx < STORE_DEPTH)
            spectrum_copy[idx] = mag;
        if (idx % 3 == 0)
        begin
            k = idx / 3;
            if (k >= 1 && k < PRODUCT_BINS)
            begin
                prod = 64'(spectrum_copy[k]) * 64'(spectrum_copy[2 * k]) * 64'(mag);
                if (prod > top_product)
                begin
                    top_product = prod;
                    top_bin = k;
                end
            end
        end
        if (bins_seen < BINS)
            bins_seen++;
        if (!is_last)
            return;

        found = (top_product != 0);
        freq = found ? (64'(top_bin) * HZ_SCALE) / 64'(BINS) : 64'd0;
        if (!found)
        begin
            if (quiet_frames + 1 > hold_limit)
            begin
                quiet_frames = hold_limit;
                shown_ind = IND_OFF;
            end
            else
                quiet_frames++;
        end
        else
        begin
            quiet_frames = 0;
            shown_ind = grade_pitch(freq);
        end
        r.indication   = shown_ind;
        r.pitch_found  = found;
        r.peak_bin     = found ? BIN_W'(top_bin) : '0;
        r.freq_centihz = freq[FREQ_W-1:0];
        pending_readings.push_back(use_typed ? typed_reading : r);
        bins_seen = 0;
        top_product = '0;
        top_bin = 0;
    endfunction

    task automatic flag_reading(input string why, input reading_t want, input reading_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected ind=%0d found=%0d bin=%0d freq=%0d", $time, why,
                     want.indication, want.pitch_found, want.peak_bin, want.freq_centihz,
                     "; got ind=%0d found=%0d bin=%0d freq=%0d",
                     got.indication, got.pitch_found, got.peak_bin, got.freq_centihz);
    endtask

    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 35);
            2: out_stall <= ((cyc_count % 7) < 3);
            default:
            begin
                if (stall_run == 0 && $urandom_range(0, 99) < 6)
                    stall_run = $urandom_range(5, 40);
                out_stall <= (stall_run != 0);
                if (stall_run != 0)
                    stall_run--;
            end
        endcase
        cyc_count++;
    end

    always @(posedge clk)
    begin : monitor
        reading_t got;
        reading_t want;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got.indication   = indication;
                got.pitch_found  = pitch_found;
                got.peak_bin     = peak_bin;
                got.freq_centihz = freq_centihz;
                if (pending_readings.size() == 0)
                    flag_reading("unexpected result", '0, got);
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.indication !== want.indication
                        || got.pitch_found !== want.pitch_found
                        || got.peak_bin !== want.peak_bin
                        || got.freq_centihz !== want.freq_centihz)
                        flag_reading("mismatch", want, got);
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                tuner_step(magnitude, last);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_idx_t'(cfg_index))
                    CFG_TARGET:    tgt_centihz = cfg_data[TARGET_W-1:0];
                    CFG_TOLERANCE: tol_centihz = cfg_data[TOL_W-1:0];
                    CFG_OFF_BAND:  off_centihz = cfg_data[OFF_W-1:0];
                    CFG_HOLD:      hold_limit  = cfg_data[HOLD_W-1:0];
                    default:       ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic put_bin(input logic [MAG_W-1:0] mag, input logic is_last);
        if (gaps_on && burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(negedge clk) in_valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        magnitude <= mag;
        last      <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic play_frame(input fill_t fill, input int len, input int k, input int bg_max,
                              input logic [MAG_W-1:0] peak, input bit typed,
                              input reading_t want);
        logic [MAG_W-1:0] spike;
        int i;
        frame_bins.delete();
        spike = (peak != 0) ? peak : MAG_W'($urandom_range(32768, 65535));
        for (i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO:   frame_bins.push_back('0);
                FILL_MAX:    frame_bins.push_back('1);
                FILL_RAND:   frame_bins.push_back(MAG_W'($urandom));
                FILL_SPARSE: frame_bins.push_back(($urandom_range(0, 9) < 3) ?
                                                  MAG_W'($urandom) : '0);
                default:     frame_bins.push_back(MAG_W'($urandom_range(0, bg_max)));
            endcase
        end
        if (fill == FILL_SPIKE || fill == FILL_TWIN)
        begin
            for (i = 1; i <= 3; i++)
            begin
                if (i * k < len)
                    frame_bins[i * k] = spike;
                if (fill == FILL_TWIN && i * (k + 2) < len)
                    frame_bins[i * (k + 2)] = spike;
            end
        end
        // Applied after this edge's sampling, so the previous frame is unaffected.
        use_typed     <= typed;
        typed_reading <= want;
        for (i = 0; i < len; i++)
            put_bin(frame_bins[i], i == len - 1);
    endtask

    task automatic random_frames(input int min_items, input int min_frames);
        int items;
        int frames;
        int len;
        int k;
        int kc;
        int pick;
        int bg;
        fill_t fill;
        items = 0;
        frames = 0;
        kc = int'((64'(tgt_centihz) * BINS) / HZ_SCALE);
        while (items < min_items || frames < min_frames)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                // A run of silent frames walks the hold counter toward its limit.
                repeat ($urandom_range(1, 9))
                begin
                    len = $urandom_range(1, 6);
                    play_frame(FILL_ZERO, len, 0, 0, '0, 1'b0, '0);
                    items += len;
                    frames++;
                end
            end
            else
            begin
                if (pick < 50)
                begin
                    fill = (pick < 35) ? FILL_RAND : FILL_SPARSE;
                    k = 0;
                    len = $urandom_range(1, 70);
                    bg = 0;
                end
                else
                begin
                    if (kc <= 80 && $urandom_range(0, 3) != 0)
                        k = kc + int'($urandom_range(0, 8)) - 4;
                    else
                        k = $urandom_range(1, 40);
                    if (k < 1)
                        k = 1;
                    if (k > PRODUCT_BINS - 1)
                        k = PRODUCT_BINS - 1;
                    fill = ($urandom_range(0, 4) == 0) ? FILL_TWIN : FILL_SPIKE;
                    len = 3 * k + 1 + $urandom_range(0, 8);
                    case ($urandom_range(0, 2))
                        0: bg = 0;
                        1: bg = 255;
                        default: bg = 4095;
                    endcase
                end
                play_frame(fill, len, k, bg, '0, 1'b0, '0);
                items += len;
                frames++;
            end
        end
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input int unsigned target, input int unsigned tol,
                               input int unsigned off_band, input int unsigned hold);
        cfg_write(CFG_TARGET, target);
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_OFF_BAND, off_band);
        cfg_write(CFG_HOLD, hold);
    endtask

    // Drains every expected reading, then lets the pipeline run empty.
    task automatic settle();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_plan[i])
            play_frame(directed_plan[i].fill, directed_plan[i].len, directed_plan[i].k, 0,
                       16'hFFFF, directed_plan[i].typed, directed_plan[i].want);
        settle();

        for (p = 1; p <= 7; p++)
        begin
            stall_mode = p % 4;
            gaps_on = (p % 3 != 1);
            case (p)
                1: load_config(0, 0, 0, 0);
                2: load_config(200000, 10000, 100000, 7);
                default:
                    load_config($urandom_range(300, 20000),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10000)
                                                            : $urandom_range(0, 400),
                                $urandom_range(0, 1) ? $urandom_range(0, 100000)
                                                     : $urandom_range(0, 3000),
                                $urandom_range(0, 7));
            endcase
            random_frames(100, 2);
            settle();
        end

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
